// ===== src/sfa_pkg.sv =====
// Package: shared constants for the single float adder.
`timescale 1ns / 1ps
package sfa_pkg;
    localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
    localparam logic [31:0] EXP_MASK  = 32'h7f80_0000;
    localparam logic [31:0] FRAC_MASK = 32'h007f_ffff;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_MAX   = 8'd255;
    localparam int unsigned GUARD_BITS = 7;
endpackage

// ===== src/sfa_core.sv =====
// Combinational single-precision add: unpack, align, add, normalize, round.
`timescale 1ns / 1ps
module sfa_core
    import sfa_pkg::*;
(
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] sum_word
);
    logic        sa, sb, sign;
    logic [7:0]  ea, eb, ea1, eb1, rexp, sh;
    logic [22:0] fa, fb;
    logic [31:0] ma, mb, sum, man, gmask;
    logic [4:0]  lead, shc;
    logic [9:0]  nexp, e;
    logic [3:0]  drop;
    logic        guard, sticky, found;

    always_comb begin
        sa = a[31]; sb = b[31];
        ea = a[30:23]; eb = b[30:23];
        fa = a[22:0]; fb = b[22:0];
        ma = {1'b0, (ea != 8'd0), fa, 7'd0};
        mb = {1'b0, (eb != 8'd0), fb, 7'd0};
        ea1 = (ea == 8'd0) ? 8'd1 : ea;
        eb1 = (eb == 8'd0) ? 8'd1 : eb;
        if (ea1 >= eb1) begin
            sh = ea1 - eb1;
            shc = (sh > 8'd31) ? 5'd31 : sh[4:0];
            mb = mb >> shc;
            rexp = ea1;
        end else begin
            sh = eb1 - ea1;
            shc = (sh > 8'd31) ? 5'd31 : sh[4:0];
            ma = ma >> shc;
            rexp = eb1;
        end
        if (sa == sb) begin
            sum = ma + mb; sign = sa;
        end else if (ma > mb) begin
            sum = ma - mb; sign = sa;
        end else if (ma < mb) begin
            sum = mb - ma; sign = sb;
        end else begin
            sum = 32'd0; sign = 1'b0;
        end
        lead = 5'd0; found = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!found && sum[i]) begin
                lead = 5'(i); found = 1'b1;
            end
        end
        nexp = 10'(rexp) + 10'(lead) - 10'd30;
        drop = 4'(lead - 5'd23);
        gmask = (32'd1 << (drop - 4'd1)) - 32'd1;
        guard = sum[drop - 4'd1];
        sticky = (sum & gmask) != 32'd0;
        man = sum >> drop;
        e = nexp;
        if (guard && (sticky || man[0])) man = man + 32'd1;
        if (man[24]) begin
            man = man >> 1; e = e + 10'd1;
        end
        if ((ea == EXP_MAX && fa != 23'd0) || (eb == EXP_MAX && fb != 23'd0))
            sum_word = CANON_NAN;
        else if (ea == EXP_MAX && eb == EXP_MAX && sa != sb)
            sum_word = CANON_NAN;
        else if (ea == EXP_MAX)
            sum_word = a;
        else if (eb == EXP_MAX)
            sum_word = b;
        else if (lead <= 5'd23)
            sum_word = {sign, 31'd0};
        else if (nexp[9] || nexp == 10'd0)
            sum_word = {sign, 31'd0};
        else if (nexp >= 10'd255 || e >= 10'd255)
            sum_word = {sign, 8'hff, 23'd0};
        else
            sum_word = {sign, e[7:0], man[22:0]};
    end
endmodule

// ===== src/single_float_adder_top.sv =====
// Top level: input register, adder logic, output register with valid/ready.
//  channel | ports                        | dir
//  input   | s_valid s_ready s_addend_a/b | in
//  result  | m_valid m_ready m_sum_word   | out
// One transaction per cycle unless stalled; m_valid trails the input register.
// Synchronous active-low reset clears valid flags only.
// Stages advance when the next stage is empty or being drained.
`timescale 1ns / 1ps
module single_float_adder_top
    import sfa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_addend_a,
    input  logic [31:0] s_addend_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_sum_word
);
    logic        in_vld_reg, out_vld_reg;
    logic [31:0] a_reg, b_reg, sum_reg, sum_next;
    logic        out_en, in_en;

    sfa_core u_core (.a(a_reg), .b(b_reg), .sum_word(sum_next));

    assign out_en  = !out_vld_reg || m_ready;
    assign in_en   = !in_vld_reg || out_en;
    assign s_ready = in_en;
    assign m_valid = out_vld_reg;
    assign m_sum_word = sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_en) in_vld_reg <= s_valid;
            if (out_en) out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_en && s_valid) begin
            a_reg <= s_addend_a;
            b_reg <= s_addend_b;
        end
        if (out_en && in_vld_reg) sum_reg <= sum_next;
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sum_word)) else $error("result lost");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && out_en |=> out_vld_reg) else $error("item dropped");
    a_nan: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && out_en && a_reg[30:23] == EXP_MAX && a_reg[22:0] != 23'd0
        |=> m_sum_word == CANON_NAN) else $error("nan");
endmodule
